FILE: hdl/ltp_pkg.sv
`timescale 1ns / 1ps

package ltp_pkg;

  // Width of one signed light channel at the input.
  localparam int LIGHT_WIDTH = 16;
  // A clamped channel is never negative, so the sign bit drops away.
  localparam int CH_W = LIGHT_WIDTH - 1;
  localparam int BYTE_W = 8;
  localparam int BYTE_MAX = 255;
  // Remainder width of the rescale divider: channel times 255.
  localparam int REM_W = CH_W + BYTE_W;
  localparam int NUM_CH = 3;

  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LUMA = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FAKED = 2'd2;
  localparam logic [MODE_W-1:0] MODE_INV_ALPHA = 2'd3;

  typedef struct packed {
    logic signed [LIGHT_WIDTH-1:0] light_red;
    logic signed [LIGHT_WIDTH-1:0] light_green;
    logic signed [LIGHT_WIDTH-1:0] light_blue;
  } light_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_red;
    logic [BYTE_W-1:0] out_green;
    logic [BYTE_W-1:0] out_blue;
    logic [BYTE_W-1:0] out_alpha;
  } texel_out_t;

  // One texel moving between pipeline sections, with its valid bit.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
  } texel_pipe_t;

endpackage

FILE: hdl/ltp_scale.sv
`timescale 1ns / 1ps

module ltp_scale (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  ltp_pkg::light_in_t  light,
  output ltp_pkg::texel_pipe_t scaled
);
  import ltp_pkg::*;

  // One stage for clamp and maximum, then one stage per quotient bit.
  localparam int STAGES = BYTE_W + 1;

  logic [STAGES-1:0] valid;
  logic [STAGES-1:0] scale;
  logic [CH_W-1:0]   divisor [STAGES];
  logic [BYTE_W-1:0] alpha [STAGES];
  logic [REM_W-1:0]  rem [STAGES][NUM_CH];
  logic [BYTE_W-1:0] quot [STAGES][NUM_CH];

  logic [REM_W-1:0]  rem_next [BYTE_W][NUM_CH];
  logic [BYTE_W-1:0] quot_next [BYTE_W][NUM_CH];

  logic [CH_W-1:0] chan [NUM_CH];
  logic [CH_W-1:0] mx_in;
  logic            scale_in;

  function automatic logic [CH_W-1:0] clamp(input logic signed [LIGHT_WIDTH-1:0] v);
    logic [CH_W-1:0] res;
    res = v[LIGHT_WIDTH-1] ? '0 : v[CH_W-1:0];
    return res;
  endfunction

  always_comb begin
    chan[0] = clamp(light.light_red);
    chan[1] = clamp(light.light_green);
    chan[2] = clamp(light.light_blue);
    mx_in = (chan[0] > chan[1]) ? chan[0] : chan[1];
    if (chan[2] > mx_in) begin
      mx_in = chan[2];
    end
    scale_in = mx_in > CH_W'(BYTE_MAX);
  end

  // Restoring division of channel*255 by the maximum, one quotient bit per stage.
  // The quotient never exceeds 255 because no channel exceeds the maximum.
  always_comb begin
    logic [REM_W-1:0] trial;
    for (int k = 0; k < BYTE_W; k++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        trial = REM_W'(divisor[k]) << (BYTE_W - 1 - k);
        rem_next[k][c] = rem[k][c];
        quot_next[k][c] = quot[k][c];
        if (scale[k] && (rem[k][c] >= trial)) begin
          rem_next[k][c] = rem[k][c] - trial;
          quot_next[k][c][BYTE_W-1-k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    scale[0]   <= scale_in;
    divisor[0] <= mx_in;
    alpha[0]   <= scale_in ? BYTE_W'(BYTE_MAX) : mx_in[BYTE_W-1:0];
    for (int c = 0; c < NUM_CH; c++) begin
      rem[0][c]  <= scale_in ? ((REM_W'(chan[c]) << BYTE_W) - REM_W'(chan[c])) : '0;
      quot[0][c] <= scale_in ? '0 : chan[c][BYTE_W-1:0];
    end
    for (int k = 1; k < STAGES; k++) begin
      scale[k]   <= scale[k-1];
      divisor[k] <= divisor[k-1];
      alpha[k]   <= alpha[k-1];
      for (int c = 0; c < NUM_CH; c++) begin
        rem[k][c]  <= rem_next[k-1][c];
        quot[k][c] <= quot_next[k-1][c];
      end
    end
  end

  assign scaled.valid = valid[STAGES-1];
  assign scaled.red   = quot[STAGES-1][0];
  assign scaled.green = quot[STAGES-1][1];
  assign scaled.blue  = quot[STAGES-1][2];
  assign scaled.alpha = alpha[STAGES-1];

endmodule

FILE: hdl/ltp_pack.sv
`timescale 1ns / 1ps

module ltp_pack (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ltp_pkg::MODE_W-1:0]  mono_mode,
  input  ltp_pkg::texel_pipe_t        scaled,
  output ltp_pkg::texel_pipe_t        packed_texel
);
  import ltp_pkg::*;

  // floor(x/3) as (x*683) >> 11, exact for sums up to 765.
  localparam int SUM_W = 10;
  localparam int RECIP3 = 683;
  localparam int RECIP3_SHIFT = 11;
  localparam int AVG_PROD_W = SUM_W + 10;
  localparam int PROD_W = 2 * BYTE_W;

  texel_pipe_t          s1;
  logic [AVG_PROD_W-1:0] avg_prod;
  texel_pipe_t          s2;
  logic [BYTE_W-1:0]    fade;
  logic [PROD_W-1:0]    prod [NUM_CH];

  logic [SUM_W-1:0]     sum;
  logic [BYTE_W-1:0]    fade_next;
  texel_pipe_t          out_next;

  // floor(x/255) for any 16-bit x up to 65279, which covers every 8-bit by 8-bit product.
  function automatic logic [BYTE_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] t;
    t = {1'b0, x} + {1'b0, (x >> BYTE_W)} + (PROD_W+1)'(1);
    return t[PROD_W-1:BYTE_W];
  endfunction

  assign sum = SUM_W'(scaled.red) + SUM_W'(scaled.green) + SUM_W'(scaled.blue);
  assign fade_next = BYTE_W'(BYTE_MAX) - BYTE_W'(avg_prod >> RECIP3_SHIFT);

  always_comb begin
    out_next.valid = s2.valid;
    unique case (mono_mode)
      MODE_NORMAL: begin
        out_next.red   = s2.red;
        out_next.green = s2.green;
        out_next.blue  = s2.blue;
        out_next.alpha = s2.alpha;
      end
      MODE_LUMA: begin
        out_next.red   = s2.alpha;
        out_next.green = '0;
        out_next.blue  = '0;
        out_next.alpha = s2.alpha;
      end
      MODE_FAKED: begin
        out_next.red   = div255(prod[0]);
        out_next.green = div255(prod[1]);
        out_next.blue  = div255(prod[2]);
        out_next.alpha = fade;
      end
      default: begin
        out_next.red   = '0;
        out_next.green = '0;
        out_next.blue  = '0;
        out_next.alpha = BYTE_W'(BYTE_MAX) - s2.alpha;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid           <= 1'b0;
      s2.valid           <= 1'b0;
      packed_texel.valid <= 1'b0;
    end else begin
      s1.valid           <= scaled.valid;
      s2.valid           <= s1.valid;
      packed_texel.valid <= out_next.valid;
    end

    s1.red   <= scaled.red;
    s1.green <= scaled.green;
    s1.blue  <= scaled.blue;
    s1.alpha <= scaled.alpha;
    avg_prod <= AVG_PROD_W'(sum) * AVG_PROD_W'(RECIP3);

    s2.red   <= s1.red;
    s2.green <= s1.green;
    s2.blue  <= s1.blue;
    s2.alpha <= s1.alpha;
    fade     <= fade_next;
    prod[0]  <= PROD_W'(s1.red) * PROD_W'(fade_next);
    prod[1]  <= PROD_W'(s1.green) * PROD_W'(fade_next);
    prod[2]  <= PROD_W'(s1.blue) * PROD_W'(fade_next);

    packed_texel.red   <= out_next.red;
    packed_texel.green <= out_next.green;
    packed_texel.blue  <= out_next.blue;
    packed_texel.alpha <= out_next.alpha;
  end

endmodule

FILE: hdl/lightmap_texel_pack.sv
// Lightmap texel packer: turns one accumulated light texel (three signed
// channels) into one RGBA byte texel.
//
// Input channel: an item is transferred at a rising clock edge where start
// is high and busy is low. busy is held low, so a texel may be presented
// in every cycle and the block sustains one texel per clock.
// Result channel: done pulses for exactly one cycle with the packed texel
// on texel. The receiver cannot hold results off, and none is needed: the
// pipeline never stalls and every result leaves in input order.
// Pipeline: one stage for clamp and maximum,
// eight stages that each produce one quotient bit of channel*255/max, then
// three stages for the average, the fade multiply and the final packing.
// Configuration: mode_we writes mode_wdata into the packing mode register
// (normal, luminance, faked color, inverted alpha). Write it only while no
// texel is in flight.
// Reset (rst, synchronous, active high) empties the pipeline, so no done
// pulse follows it, and sets the mode to normal.
`timescale 1ns / 1ps

module lightmap_texel_pack (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  ltp_pkg::light_in_t         light,
  input  logic                       mode_we,
  input  logic [ltp_pkg::MODE_W-1:0] mode_wdata,
  output logic                       done,
  output ltp_pkg::texel_out_t        texel
);
  import ltp_pkg::*;

  logic [MODE_W-1:0] mono_mode;
  logic              accept;
  texel_pipe_t       scaled;
  texel_pipe_t       packed_texel;

  // The pipeline advances every cycle, so input is always welcome.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mono_mode <= MODE_NORMAL;
    end else if (mode_we) begin
      mono_mode <= mode_wdata;
    end
  end

  // Clamp, find the brightest channel and rescale to 255 when it overflows.
  ltp_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .light    (light),
    .scaled   (scaled)
  );

  // Apply the selected packing mode.
  ltp_pack u_pack (
    .clk          (clk),
    .rst          (rst),
    .mono_mode    (mono_mode),
    .scaled       (scaled),
    .packed_texel (packed_texel)
  );

  assign done            = packed_texel.valid;
  assign texel.out_red   = packed_texel.red;
  assign texel.out_green = packed_texel.green;
  assign texel.out_blue  = packed_texel.blue;
  assign texel.out_alpha = packed_texel.alpha;

endmodule
